// ===== hdl/pilot_referenced_sample_normaliser_defines.svh =====
// Assertion helpers shared by the normaliser RTL.
`ifndef PILOT_REFERENCED_SAMPLE_NORMALISER_DEFINES_SVH
`define PILOT_REFERENCED_SAMPLE_NORMALISER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PRSN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PRSN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/prsn_pkg.sv =====
// ----------------------------------------------------------------------------
// prsn_pkg
// Types, codes and fixed widths of the pilot-referenced sample normaliser.
// ----------------------------------------------------------------------------
package prsn_pkg;

  localparam int LEVEL_W  = 16;
  localparam int COORD_W  = 12;
  localparam int FRAC_W   = 8;
  localparam int NODE_W   = 10;
  localparam int NODES    = 1024;
  localparam int SIDE_W   = 6;
  localparam int SIDE_MAX = 32;
  localparam int SCALE    = 255 * 64;

  // Pipelined long division: steps per stage and stage counts.
  localparam int DIV_SPS    = 4;
  localparam int LOC_QW     = COORD_W + FRAC_W;
  localparam int LOC_ST     = (LOC_QW + DIV_SPS - 1) / DIV_SPS;
  localparam int QUO_QW     = 15;
  localparam int QUO_DW     = LEVEL_W + 1;
  localparam int QUO_ST     = (QUO_QW + DIV_SPS - 1) / DIV_SPS;

  localparam logic [2:0] CFG_PITCH = 3'd0;
  localparam logic [2:0] CFG_COLS  = 3'd1;
  localparam logic [2:0] CFG_ROWS  = 3'd2;
  localparam logic [2:0] CFG_MINSEP = 3'd3;
  localparam logic [2:0] CFG_RATIO = 3'd4;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    CAUSE_NONE    = 2'd0,
    CAUSE_INVALID = 2'd1,
    CAUSE_LOW     = 2'd2,
    CAUSE_PILOT   = 2'd3
  } cause_t;

  typedef struct packed {
    logic               func;
    logic [NODE_W-1:0]  node_index;
    logic [LEVEL_W-1:0] bright_level;
    logic [LEVEL_W-1:0] dark_level;
    logic [LEVEL_W-1:0] node_residual;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [LEVEL_W-1:0] sample;
    logic               sample_valid;
  } in_t;

  typedef struct packed {
    logic signed [15:0] normalized;
    logic               erased;
    cause_t             erase_cause;
  } out_t;

  // Lattice side in use: zero acts as one, anything above the maximum clamps.
  function automatic logic [SIDE_W-1:0] side_of(input logic [SIDE_W-1:0] v);
    if (v == '0) return SIDE_W'(1);
    if (v > SIDE_W'(SIDE_MAX)) return SIDE_W'(SIDE_MAX);
    return v;
  endfunction

endpackage

// ===== hdl/prsn_ram.sv =====
// ----------------------------------------------------------------------------
// prsn_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module prsn_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== hdl/prsn_div.sv =====
// ----------------------------------------------------------------------------
// prsn_div
// Pipelined restoring divider, a few quotient bits per stage.
// ----------------------------------------------------------------------------
module prsn_div #(
  parameter int Q_W = 20,
  parameter int D_W = 8,
  parameter int SPS = 4
) (
  input  logic           clk,
  input  logic           en,
  input  logic [D_W-1:0] rem_init,  // must be below den
  input  logic [Q_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic [Q_W-1:0] quo
);

  localparam int NST = (Q_W + SPS - 1) / SPS;

  logic [D_W-1:0] rem_r  [NST];
  logic [Q_W-1:0] work_r [NST];
  logic [D_W-1:0] den_r  [NST-1];  // last stage needs no divisor

  for (genvar g = 0; g < NST; g++) begin : g_st
    logic [D_W-1:0] src_rem;
    logic [Q_W-1:0] src_work;
    logic [D_W-1:0] src_den;
    logic [D_W-1:0] rem_nxt;
    logic [Q_W-1:0] work_nxt;

    if (g == 0) begin : g_first
      assign src_rem  = rem_init;
      assign src_work = num;
      assign src_den  = den;
    end else begin : g_rest
      assign src_rem  = rem_r[g-1];
      assign src_work = work_r[g-1];
      assign src_den  = den_r[g-1];
    end

    always_comb begin
      logic [D_W:0] ext;
      logic         ge;
      ext      = '0;
      ge       = 1'b0;
      rem_nxt  = src_rem;
      work_nxt = src_work;
      for (int t = 0; t < SPS; t++) begin
        if (g * SPS + t < Q_W) begin
          ext      = {rem_nxt, work_nxt[Q_W-1]};
          ge       = ext >= {1'b0, src_den};
          work_nxt = {work_nxt[Q_W-2:0], ge};
          if (ge) ext = ext - {1'b0, src_den};
          rem_nxt  = ext[D_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= rem_nxt;
        work_r[g] <= work_nxt;
      end
    end

    if (g < NST - 1) begin : g_den
      always_ff @(posedge clk) begin
        if (en) den_r[g] <= src_den;
      end
    end
  end

  assign quo = work_r[NST-1];

endmodule

// ===== hdl/pilot_referenced_sample_normaliser.sv =====
// ----------------------------------------------------------------------------
// pilot_referenced_sample_normaliser
// Bilinear flat-field correction of samples against a stored node lattice.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) carries two kinds of item. A load
// (func 0) writes one lattice node's bright, dark and residual levels and
// gives no result. A sample (func 1) gives exactly one result on the output
// channel (out_valid/out_ready/out_data): the normalized level, or an erase
// flag with its cause. Results leave in input order.
// Throughput is one item per cycle while the receiver does not stall. The
// transfer edge loads the first of five coordinate divider stages; then come
// the node RAM read, two interpolation multiply stages, a contrast/scale
// stage, a check stage, four output divider stages and the output register.
// Node levels live in four RAM copies (one per bilinear corner), written
// together by a load in pipeline order, so a sample sees every earlier load.
// Reset clears the pipeline valids and sets the configuration registers to
// their defaults; node memory is unknown until loaded. When the receiver
// stalls, the whole pipeline holds and in_ready drops until out_ready. Users
// write configuration on cfg_we only while the block is idle; not enforced.
// ----------------------------------------------------------------------------
module pilot_referenced_sample_normaliser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  prsn_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output prsn_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [15:0]    cfg_wdata
);
  import prsn_pkg::*;
`include "pilot_referenced_sample_normaliser_defines.svh"

  localparam int WORD0_W = 3 * LEVEL_W;
  localparam int WORD_W  = 2 * LEVEL_W;

  // -------------------------------------------------------------- config
  logic [7:0]  pitch_r;
  logic [5:0]  cols_r;
  logic [5:0]  rows_r;
  logic [15:0] minsep_r;
  logic [11:0] ratio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r  <= 8'd16;
      cols_r   <= 6'd1;
      rows_r   <= 6'd1;
      minsep_r <= 16'd16;
      ratio_r  <= 12'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PITCH:  pitch_r  <= cfg_wdata[7:0];
        CFG_COLS:   cols_r   <= cfg_wdata[5:0];
        CFG_ROWS:   rows_r   <= cfg_wdata[5:0];
        CFG_MINSEP: minsep_r <= cfg_wdata;
        CFG_RATIO:  ratio_r  <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  logic [7:0]        pitch_e;
  logic [SIDE_W-1:0] cols_e;
  logic [SIDE_W-1:0] rows_e;
  assign pitch_e = (pitch_r == 8'd0) ? 8'd16 : pitch_r;
  assign cols_e  = side_of(cols_r);
  assign rows_e  = side_of(rows_r);

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ------------------------------------------------- coordinate dividers
  logic [LOC_ST-1:0] l_v_r;
  in_t               l_d_r [LOC_ST];
  logic [LOC_QW-1:0] colq;
  logic [LOC_QW-1:0] rowq;

  always_ff @(posedge clk) begin
    if (!rst_n) l_v_r <= '0;
    else if (adv) l_v_r <= {l_v_r[LOC_ST-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l_d_r[0] <= in_data;
      for (int k = 1; k < LOC_ST; k++) l_d_r[k] <= l_d_r[k-1];
    end
  end

  prsn_div #(.Q_W(LOC_QW), .D_W(8), .SPS(DIV_SPS)) u_div_col (
    .clk(clk), .en(adv), .rem_init(8'd0),
    .num({in_data.col, FRAC_W'(0)}), .den(pitch_e), .quo(colq)
  );

  prsn_div #(.Q_W(LOC_QW), .D_W(8), .SPS(DIV_SPS)) u_div_row (
    .clk(clk), .en(adv), .rem_init(8'd0),
    .num({in_data.row, FRAC_W'(0)}), .den(pitch_e), .quo(rowq)
  );

  // ------------------------------------------------------ address stage
  // Returns {node, fraction}; at or beyond the last node clamps with no fraction.
  function automatic logic [4+FRAC_W:0] locate(input logic [LOC_QW-1:0] q,
                                               input logic [SIDE_W-1:0] side);
    logic [4:0] last;
    last = 5'(side - SIDE_W'(1));
    if (q[LOC_QW-1:FRAC_W] >= COORD_W'(last)) return {last, FRAC_W'(0)};
    return {q[FRAC_W+4:FRAC_W], q[FRAC_W-1:0]};
  endfunction

  function automatic logic [4:0] next_of(input logic [4:0] i,
                                         input logic [SIDE_W-1:0] side);
    logic [SIDE_W-1:0] n;
    n = SIDE_W'(i) + SIDE_W'(1);
    if (n < side) return n[4:0];
    return 5'(side - SIDE_W'(1));
  endfunction

  function automatic logic [NODE_W-1:0] node_addr(input logic [4:0] c,
                                                  input logic [4:0] r,
                                                  input logic [SIDE_W-1:0] cols);
    logic [10:0] a;
    a = 11'(r) * 11'(cols) + 11'(c);
    return a[NODE_W-1:0];
  endfunction

  in_t               a_d;
  logic              a_v;
  logic [4:0]        i0, i1, j0, j1;
  logic [FRAC_W-1:0] fx, fy;
  logic [NODE_W-1:0] ad0, ad1, ad2, ad3;
  logic              ram_we;

  assign a_d = l_d_r[LOC_ST-1];
  assign a_v = l_v_r[LOC_ST-1];
  assign {i0, fx} = locate(colq, cols_e);
  assign {j0, fy} = locate(rowq, rows_e);
  assign i1  = next_of(i0, cols_e);
  assign j1  = next_of(j0, rows_e);
  assign ad0 = node_addr(i0, j0, cols_e);
  assign ad1 = node_addr(i1, j0, cols_e);
  assign ad2 = node_addr(i0, j1, cols_e);
  assign ad3 = node_addr(i1, j1, cols_e);
  // Loads write as they leave this stage; later samples read after them.
  assign ram_we = adv && a_v && (a_d.func == FUNC_LOAD);

  logic [WORD0_W-1:0] rd0;
  logic [WORD_W-1:0]  rd1, rd2, rd3;

  prsn_ram #(.W(WORD0_W), .DEPTH(NODES)) u_ram0 (
    .clk(clk), .we(ram_we), .waddr(a_d.node_index),
    .wdata({a_d.node_residual, a_d.dark_level, a_d.bright_level}),
    .re(adv), .raddr(ad0), .rdata(rd0)
  );
  prsn_ram #(.W(WORD_W), .DEPTH(NODES)) u_ram1 (
    .clk(clk), .we(ram_we), .waddr(a_d.node_index),
    .wdata({a_d.dark_level, a_d.bright_level}),
    .re(adv), .raddr(ad1), .rdata(rd1)
  );
  prsn_ram #(.W(WORD_W), .DEPTH(NODES)) u_ram2 (
    .clk(clk), .we(ram_we), .waddr(a_d.node_index),
    .wdata({a_d.dark_level, a_d.bright_level}),
    .re(adv), .raddr(ad2), .rdata(rd2)
  );
  prsn_ram #(.W(WORD_W), .DEPTH(NODES)) u_ram3 (
    .clk(clk), .we(ram_we), .waddr(a_d.node_index),
    .wdata({a_d.dark_level, a_d.bright_level}),
    .re(adv), .raddr(ad3), .rdata(rd3)
  );

  logic               r_v_r;
  logic [FRAC_W-1:0]  r_fx_r, r_fy_r;
  logic [LEVEL_W-1:0] r_smp_r;
  logic               r_sv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) r_v_r <= 1'b0;
    else if (adv) r_v_r <= a_v && (a_d.func == FUNC_SAMPLE);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_fx_r  <= fx;
      r_fy_r  <= fy;
      r_smp_r <= a_d.sample;
      r_sv_r  <= a_d.sample_valid;
    end
  end

  // ------------------------------------------------ horizontal blend
  logic [8:0]         wx;
  logic               m1_v_r;
  logic [23:0]        m1_bt_r, m1_bb_r, m1_dt_r, m1_db_r;
  logic [LEVEL_W-1:0] m1_res_r, m1_smp_r;
  logic [FRAC_W-1:0]  m1_fy_r;
  logic               m1_sv_r;

  assign wx = 9'd256 - 9'(r_fx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) m1_v_r <= 1'b0;
    else if (adv) m1_v_r <= r_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_bt_r  <= 24'(25'(rd0[15:0]) * 25'(wx) + 25'(rd1[15:0]) * 25'(r_fx_r));
      m1_bb_r  <= 24'(25'(rd2[15:0]) * 25'(wx) + 25'(rd3[15:0]) * 25'(r_fx_r));
      m1_dt_r  <= 24'(25'(rd0[31:16]) * 25'(wx) + 25'(rd1[31:16]) * 25'(r_fx_r));
      m1_db_r  <= 24'(25'(rd2[31:16]) * 25'(wx) + 25'(rd3[31:16]) * 25'(r_fx_r));
      m1_res_r <= rd0[47:32];
      m1_smp_r <= r_smp_r;
      m1_fy_r  <= r_fy_r;
      m1_sv_r  <= r_sv_r;
    end
  end

  // -------------------------------------------------- vertical blend
  logic [8:0]         wy;
  logic [33:0]        bv, dv;
  logic               m2_v_r;
  logic [LEVEL_W-1:0] m2_br_r, m2_dk_r, m2_res_r, m2_smp_r;
  logic               m2_sv_r;

  assign wy = 9'd256 - 9'(m1_fy_r);
  assign bv = 34'(m1_bt_r) * 34'(wy) + 34'(m1_bb_r) * 34'(m1_fy_r) + 34'd32768;
  assign dv = 34'(m1_dt_r) * 34'(wy) + 34'(m1_db_r) * 34'(m1_fy_r) + 34'd32768;

  always_ff @(posedge clk) begin
    if (!rst_n) m2_v_r <= 1'b0;
    else if (adv) m2_v_r <= m1_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_br_r  <= bv[31:16];
      m2_dk_r  <= dv[31:16];
      m2_res_r <= m1_res_r;
      m2_smp_r <= m1_smp_r;
      m2_sv_r  <= m1_sv_r;
    end
  end

  // ------------------------------------------ contrast and scale stage
  logic [16:0]        sep, diff;
  logic [LEVEL_W-1:0] absd;
  logic               c_v_r, c_low_r, c_neg_r, c_sv_r;
  logic [15:0]        c_sep_r;
  logic [27:0]        c_prod_r;
  logic [29:0]        c_mag_r;
  logic [LEVEL_W-1:0] c_res_r;

  assign sep  = {1'b0, m2_br_r} - {1'b0, m2_dk_r};
  assign diff = {1'b0, m2_smp_r} - {1'b0, m2_dk_r};
  assign absd = diff[16] ? 16'(-diff) : diff[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else if (adv) c_v_r <= m2_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_low_r  <= sep[16] || (sep == 17'd0) || (sep[15:0] < minsep_r);
      c_sep_r  <= sep[15:0];
      c_prod_r <= 28'(ratio_r) * 28'(sep[15:0]);
      c_mag_r  <= 30'(absd) * 30'(SCALE);
      c_neg_r  <= diff[16];
      c_res_r  <= m2_res_r;
      c_sv_r   <= m2_sv_r;
    end
  end

  // --------------------------------------------- erase check, rounding
  cause_t      cause;
  logic [31:0] dnum;
  logic [16:0] dden;
  logic        d_v_r, d_ovf_r, d_neg_r;
  cause_t      d_cause_r;
  logic [31:0] d_num_r;
  logic [16:0] d_den_r;

  always_comb begin
    if (!c_sv_r) cause = CAUSE_INVALID;
    else if (c_low_r) cause = CAUSE_LOW;
    else if ({4'b0, c_res_r, 8'b0} > c_prod_r) cause = CAUSE_PILOT;
    else cause = CAUSE_NONE;
  end

  assign dnum = {1'b0, c_mag_r, 1'b0} + 32'(c_sep_r);
  assign dden = {c_sep_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) d_v_r <= 1'b0;
    else if (adv) d_v_r <= c_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_cause_r <= cause;
      d_num_r   <= dnum;
      d_den_r   <= dden;
      d_ovf_r   <= dnum >= {dden, 15'b0};  // quotient would not fit 15 bits
      d_neg_r   <= c_neg_r;
    end
  end

  // ---------------------------------------------------- output divider
  logic [QUO_ST-1:0] q_v_r;
  cause_t            q_cause_r [QUO_ST];
  logic [QUO_ST-1:0] q_ovf_r, q_neg_r;
  logic [QUO_QW-1:0] quo;

  always_ff @(posedge clk) begin
    if (!rst_n) q_v_r <= '0;
    else if (adv) q_v_r <= {q_v_r[QUO_ST-2:0], d_v_r};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_cause_r[0] <= d_cause_r;
      for (int k = 1; k < QUO_ST; k++) q_cause_r[k] <= q_cause_r[k-1];
      q_ovf_r <= {q_ovf_r[QUO_ST-2:0], d_ovf_r};
      q_neg_r <= {q_neg_r[QUO_ST-2:0], d_neg_r};
    end
  end

  prsn_div #(.Q_W(QUO_QW), .D_W(QUO_DW), .SPS(DIV_SPS)) u_div_out (
    .clk(clk), .en(adv), .rem_init(d_num_r[31:15]),
    .num(d_num_r[14:0]), .den(d_den_r), .quo(quo)
  );

  // ---------------------------------------------------- output register
  cause_t f_cause;
  logic   f_ovf, f_neg;
  out_t   out_nxt;
  out_t   out_data_r;
  logic   out_valid_r;

  assign f_cause = q_cause_r[QUO_ST-1];
  assign f_ovf   = q_ovf_r[QUO_ST-1];
  assign f_neg   = q_neg_r[QUO_ST-1];

  always_comb begin
    out_nxt.erased      = (f_cause != CAUSE_NONE);
    out_nxt.erase_cause = f_cause;
    if (f_cause != CAUSE_NONE) out_nxt.normalized = 16'sd0;
    else if (f_neg) out_nxt.normalized = f_ovf ? 16'sh8000 : -$signed({1'b0, quo});
    else out_nxt.normalized = f_ovf ? 16'sd32767 : $signed({1'b0, quo});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= q_v_r[QUO_ST-1];
  end

  always_ff @(posedge clk) begin
    if (adv) out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // -------------------------------------------------------- assertions
  `PRSN_ASSERT_NOW(a_erase_code, out_valid,
    out_data.erased == (out_data.erase_cause != CAUSE_NONE), "erase flag and cause disagree")
  `PRSN_ASSERT_NOW(a_erase_zero, out_valid && out_data.erased,
    out_data.normalized == 16'sd0, "erased result carries a level")
  `PRSN_ASSERT_NOW(a_ready_stall, !in_ready,
    out_valid && !out_ready, "input blocked without an output stall")
  `PRSN_ASSERT_NEXT(a_hold_pipe, !adv,
    $stable(m2_br_r) && $stable(q_v_r) && $stable(d_num_r), "pipeline moved while stalled")

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Normaliser testbench
// Drives lattice loads and sample items through the valid/ready channels and
// compares every result against a bit-accurate bilinear normalisation model.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import prsn_pkg::*;

  class norm_scoreboard;
    logic [15:0] bright_mem [NODES];
    logic [15:0] dark_mem [NODES];
    logic [15:0] resid_mem [NODES];
    bit          loaded [NODES];
    logic [7:0]  pitch_r;
    logic [5:0]  cols_r, rows_r;
    logic [15:0] minsep_r;
    logic [11:0] ratio_r;
    out_t        pending [$];
    int          errors;

    function new();
      pitch_r = 8'd16; cols_r = 6'd1; rows_r = 6'd1; minsep_r = 16'd16; ratio_r = 12'd64;
      errors = 0;
      foreach (loaded[i]) loaded[i] = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] v);
      case (idx)
        CFG_PITCH:  pitch_r = v[7:0];
        CFG_COLS:   cols_r = v[5:0];
        CFG_ROWS:   rows_r = v[5:0];
        CFG_MINSEP: minsep_r = v;
        CFG_RATIO:  ratio_r = v[11:0];
        default: ;
      endcase
    endfunction

    function int side(logic [5:0] v);
      if (v == 0) return 1;
      if (v > SIDE_MAX) return SIDE_MAX;
      return v;
    endfunction

    function int node_at(int c, int r);
      return (r * side(cols_r) + c) % NODES;
    endfunction

    function void locate(int pos, int pt, int sd, output int n, output int f);
      int i;
      i = pos / pt;
      if (i >= sd - 1) begin
        n = sd - 1; f = 0;
      end else begin
        n = i; f = ((pos % pt) << 8) / pt;
      end
    endfunction

    function longint blend(longint a, longint b, longint c, longint d, int fx, int fy);
      longint top, bot;
      top = a * (256 - fx) + b * fx;
      bot = c * (256 - fx) + d * fx;
      return (top * (256 - fy) + bot * fy + 32768) >>> 16;
    endfunction

    function void note_item(in_t it);
      int pt, nc, nr, i0, i1, j0, j1, fx, fy, a0, a1, a2, a3;
      longint br, dk, sep, num, mag, q;
      out_t e;
      if (it.func == FUNC_LOAD) begin
        bright_mem[it.node_index] = it.bright_level;
        dark_mem[it.node_index] = it.dark_level;
        resid_mem[it.node_index] = it.node_residual;
        loaded[it.node_index] = 1;
        return;
      end
      e.normalized = '0; e.erased = 1; e.erase_cause = CAUSE_INVALID;
      if (it.sample_valid) begin
        pt = (pitch_r == 0) ? 16 : pitch_r;
        nc = side(cols_r); nr = side(rows_r);
        locate(it.col, pt, nc, i0, fx);
        locate(it.row, pt, nr, j0, fy);
        i1 = (i0 + 1 < nc) ? i0 + 1 : nc - 1;
        j1 = (j0 + 1 < nr) ? j0 + 1 : nr - 1;
        a0 = node_at(i0, j0); a1 = node_at(i1, j0);
        a2 = node_at(i0, j1); a3 = node_at(i1, j1);
        br = blend(bright_mem[a0], bright_mem[a1], bright_mem[a2], bright_mem[a3], fx, fy);
        dk = blend(dark_mem[a0], dark_mem[a1], dark_mem[a2], dark_mem[a3], fx, fy);
        sep = br - dk;
        if (sep <= 0 || sep < minsep_r) e.erase_cause = CAUSE_LOW;
        else if (longint'(resid_mem[a0]) * 256 > longint'(ratio_r) * sep)
          e.erase_cause = CAUSE_PILOT;
        else begin
          num = (longint'(it.sample) - dk) * SCALE;
          mag = num < 0 ? -num : num;
          q = (2 * mag + sep) / (2 * sep);
          if (num < 0) q = -q;
          if (q > 32767) q = 32767;
          if (q < -32768) q = -32768;
          e.normalized = q[15:0]; e.erased = 0; e.erase_cause = CAUSE_NONE;
        end
      end
      pending = {pending, e};
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.normalized !== e.normalized) begin
        $error("normalized: expected %0d, got %0d", e.normalized, got.normalized);
        errors++;
      end
      if (got.erased !== e.erased) begin
        $error("erased: expected %0b, got %0b", e.erased, got.erased);
        errors++;
      end
      if (got.erase_cause !== e.erase_cause) begin
        $error("erase_cause: expected %0d, got %0d", e.erase_cause, got.erase_cause);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_t  in_data;
  out_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [15:0] cfg_wdata;

  norm_scoreboard sb;
  bit   quiet;      // no idling in the final stretch
  bit   hold_off;   // request a long receiver stall
  int   cycles;

  pilot_referenced_sample_normaliser dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    int n;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 0;
        repeat (60) @(negedge clk);
        hold_off = 0;
        out_ready <= 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 7);
        out_ready <= 0;
        repeat (n - 1) @(negedge clk);
      end else out_ready <= 1;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);

  task automatic send(in_t it);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(it);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Leaves cfg_we high; the caller drops it after the last write.
  task automatic write_reg(logic [2:0] idx, logic [15:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(negedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic setup(int pt, int nc, int nr, int ms, int rt);
    drain();
    write_reg(CFG_PITCH, 16'(pt));
    write_reg(CFG_COLS, 16'(nc));
    write_reg(CFG_ROWS, 16'(nr));
    write_reg(CFG_MINSEP, 16'(ms));
    write_reg(CFG_RATIO, 16'(rt));
    cfg_we <= 0;
  endtask

  function automatic in_t load_item(int idx, bit wild);
    in_t it;
    int d;
    it = in_t'({$urandom, $urandom, $urandom, $urandom});
    it.func = FUNC_LOAD;
    it.node_index = NODE_W'(idx);
    if (!wild) begin
      d = $urandom_range(0, 30000);
      it.dark_level = LEVEL_W'(d);
      it.bright_level = LEVEL_W'(d + $urandom_range(0, 35535));
      it.node_residual = LEVEL_W'($urandom_range(0, 3000));
    end
    return it;
  endfunction

  function automatic in_t sample_item(bit bad);
    in_t it;
    it = in_t'({$urandom, $urandom, $urandom, $urandom});
    it.func = FUNC_SAMPLE;
    it.sample_valid = bad ? 1'b0 : ($urandom_range(0, 15) != 0);
    if ($urandom_range(0, 3) != 0) begin
      it.col = COORD_W'($urandom_range(0, 600));
      it.row = COORD_W'($urandom_range(0, 600));
    end
    return it;
  endfunction

  // Fill the first n nodes so no sample reads an unwritten entry.
  task automatic fill_lattice(int n, bit wild);
    for (int i = 0; i < n; i++) send(load_item(i, wild));
  endtask

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++)
      if ($urandom_range(0, 4) == 0) send(load_item($urandom_range(0, NODES - 1), 0));
      else send(sample_item(0));
  endtask

  initial begin
    in_t it;
    sb = new();
    rst_n = 0; in_valid = 0; in_data = '0; cfg_we = 0; cfg_index = CFG_PITCH;
    cfg_wdata = 0; quiet = 0; hold_off = 0; cycles = 0;
    repeat (8) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Reset settings: 1x1 lattice, only node 0 is read.
    it = load_item(0, 0);
    it.bright_level = 16'hFFFF; it.dark_level = '0; it.node_residual = '0;
    send(it);
    it = sample_item(0); it.sample_valid = 1; it.sample = 16'hFFFF; send(it);
    it.sample = '0; send(it);
    send(sample_item(1));
    it = load_item(0, 0);
    it.bright_level = 16'd100; it.dark_level = 16'd95; send(it);   // low contrast
    it = sample_item(0); it.sample_valid = 1; send(it);
    it = load_item(0, 0);
    it.bright_level = '0; it.dark_level = 16'hFFFF; send(it); // negative contrast
    it = sample_item(0); it.sample_valid = 1; send(it);
    it = load_item(0, 0);
    it.bright_level = 16'd1000; it.dark_level = 16'd900; it.node_residual = 16'hFFFF;
    send(it);
    it = sample_item(0); it.sample_valid = 1; send(it);      // pilot disagreement
    it = load_item(0, 0);
    it.bright_level = 16'd40; it.dark_level = 16'd20; it.node_residual = '0; send(it);
    it = sample_item(0); it.sample_valid = 1; it.sample = 16'hFFFF; send(it); // +sat
    it.sample = '0; it.dark_level = '0; send(it);
    it = load_item(0, 0);
    it.bright_level = 16'hFFFF; it.dark_level = 16'hFF00; send(it);
    it = sample_item(0); it.sample_valid = 1; it.sample = '0; send(it);       // -sat

    // Pitch zero, out-of-range sizes (0 and 63), min separation zero.
    setup(0, 63, 0, 0, 4095);
    fill_lattice(32, 0);
    random_phase(100);

    // Receiver holds off while items keep coming.
    hold_off = 1;
    random_phase(80);

    setup(1, 32, 32, 65535, 0);
    fill_lattice(NODES, 1);
    random_phase(60);

    setup(255, 5, 7, 16, 64);
    random_phase(100);
    setup(3, 17, 9, 200, 300);
    random_phase(100);
    setup(16, 32, 32, 1, 2048);
    random_phase(100);

    quiet = 1;
    random_phase(90);
    drain();

    if (sb.errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end
endmodule
